/* hw/rtl/tbwf_pkg.sv */
// Shared types and constants for the tile background/window pixel fetcher.
// Used by tbwf_ctrl, tbwf_datapath and the top level; no dependencies.
package tbwf_pkg;

  // Default geometry of the display.
  localparam int LineWidthDef    = 160;
  localparam int VisibleLinesDef = 144;
  localparam int TotalLinesDef   = 154;

  // Line counter value after reset.
  localparam logic [7:0] LineReset = 8'd144;

  // Operation codes of an input word.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_DOT   = 2'd1;
  localparam logic [1:0] OP_EOL   = 2'd2;
  localparam logic [1:0] OP_IDLE  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_LCDC = 3'd0;
  localparam logic [2:0] REG_SCX  = 3'd1;
  localparam logic [2:0] REG_SCY  = 3'd2;
  localparam logic [2:0] REG_WX   = 3'd3;
  localparam logic [2:0] REG_WY   = 3'd4;
  localparam logic [2:0] REG_BGP  = 3'd5;

  // Tile map bases as offsets into video memory.
  localparam logic [12:0] MapLow  = 13'h1800;
  localparam logic [12:0] MapHigh = 13'h1C00;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DOT,
    S_DISC,
    S_MAP,
    S_TILE,
    S_LO,
    S_HI,
    S_PIX,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic decode;
    logic dot_start;
    logic disc;
    logic map;
    logic tile;
    logic lo;
    logic hi;
    logic pix;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       line_full;
    logic       fifo_empty;
    logic       need_fetch;
    logic       out_free;
  } sts_t;

endpackage

/* hw/rtl/tbwf_ctrl.sv */
// Sequencer for the pixel fetcher: decodes a word and steps the fetch.
// Depends on tbwf_pkg; drives tbwf_datapath through cmd_t.
module tbwf_ctrl
  import tbwf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = (sts.op == OP_DOT) ? S_DOT : S_EMIT;
      end
      S_DOT: begin
        if (sts.line_full) state_next = S_EMIT;
        else if (sts.fifo_empty) state_next = S_MAP;
        else state_next = S_DISC;
      end
      S_DISC: begin
        state_next = sts.need_fetch ? S_MAP : S_PIX;
      end
      S_MAP:  state_next = S_TILE;
      S_TILE: state_next = S_LO;
      S_LO:   state_next = S_HI;
      S_HI:   state_next = S_DISC;
      S_PIX:  state_next = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE:   in_stall = 1'b0;
      S_DECODE: cmd.decode = 1'b1;
      S_DOT:    cmd.dot_start = 1'b1;
      S_DISC:   cmd.disc = 1'b1;
      S_MAP:    cmd.map = 1'b1;
      S_TILE:   cmd.tile = 1'b1;
      S_LO:     cmd.lo = 1'b1;
      S_HI:     cmd.hi = 1'b1;
      S_PIX:    cmd.pix = 1'b1;
      S_EMIT:   cmd.emit = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

endmodule

/* hw/rtl/tbwf_datapath.sv */
// Datapath of the pixel fetcher: registers, video memory, pixel FIFO, output word.
// Depends on tbwf_pkg; steered by tbwf_ctrl through cmd_t.
module tbwf_datapath
  import tbwf_pkg::*;
#(
  parameter int LINE_WIDTH    = LineWidthDef,
  parameter int VISIBLE_LINES = VisibleLinesDef,
  parameter int TOTAL_LINES   = TotalLinesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_data,
  input  logic        in_accept,
  input  logic [1:0]  opcode,
  input  logic [12:0] mem_addr,
  input  logic [7:0]  mem_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pixel_valid,
  output logic [7:0]  pixel_pos,
  output logic [1:0]  shade,
  output logic [7:0]  line_number,
  output logic        in_vblank,
  output logic        vblank_irq
);

  // Configuration registers.
  logic [7:0] lcdc, scx, scy, wx, wy, bgp;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcdc <= '0; scx <= '0; scy <= '0; wx <= '0; wy <= '0; bgp <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_LCDC: lcdc <= cfg_data;
        REG_SCX:  scx  <= cfg_data;
        REG_SCY:  scy  <= cfg_data;
        REG_WX:   wx   <= cfg_data;
        REG_WY:   wy   <= cfg_data;
        REG_BGP:  bgp  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured input word.
  logic [1:0]  op;
  logic [12:0] waddr;
  logic [7:0]  wdata;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op <= opcode;
      waddr <= mem_addr;
      wdata <= mem_data;
    end
  end

  // Line state.
  logic [8:0] bg_cnt, win_cnt;
  logic [7:0] cur_line, win_line;
  logic       win_seen, in_win;
  logic [3:0] fifo_count;
  logic [2:0] discard_left;
  logic [4:0] tiles_fetched;
  logic [1:0] fifo [8];

  // Fetch scratch and staged result.
  logic [12:0] data_addr;
  logic [2:0]  row;
  logic [7:0]  lo_byte;
  logic        res_valid, res_irq;
  logic [7:0]  res_pos;
  logic [1:0]  res_shade;

  // Video memory with a registered read port.
  logic [7:0]  vmem [8192];
  logic [7:0]  rd_data;
  logic [12:0] rd_addr;

  // Line end: next line number.
  logic [8:0] nl;
  assign nl = {1'b0, cur_line} + 9'd1;

  // Dot admission and line length.
  logic [9:0] total;
  assign total = {1'b0, bg_cnt} + {1'b0, win_cnt};

  // Discard and window entry decision.
  logic [3:0] cnt_after;
  logic       win_go;
  assign cnt_after = (fifo_count > {1'b0, discard_left}) ?
                     fifo_count - {1'b0, discard_left} : 4'd0;
  assign win_go = !in_win && lcdc[5] && win_seen &&
                  ({1'b0, bg_cnt} + 10'd7 >= {2'b0, wx});

  // Tile map address.
  logic [7:0]  sy;
  logic [4:0]  tx, ty;
  logic [12:0] map_addr, tile_addr;
  always_comb begin
    sy = scy + cur_line;
    if (in_win) begin
      tx = win_cnt[7:3];
      ty = win_line[7:3];
      map_addr = (lcdc[6] ? MapHigh : MapLow) + {3'b0, ty, tx};
    end else begin
      tx = scx[7:3] + tiles_fetched;
      ty = sy[7:3];
      map_addr = (lcdc[3] ? MapHigh : MapLow) + {3'b0, ty, tx};
    end
  end

  // Tile data address, unsigned or signed tile numbers.
  always_comb begin
    if (lcdc[4]) tile_addr = {1'b0, rd_data, 4'b0};
    else if (rd_data[7]) tile_addr = {2'b01, rd_data[6:0], 4'b0};
    else tile_addr = {2'b10, rd_data[6:0], 4'b0};
    tile_addr = tile_addr + {9'b0, row, 1'b0};
  end

  // Read address selection.
  always_comb begin
    if (cmd.map) rd_addr = map_addr;
    else if (cmd.tile) rd_addr = tile_addr;
    else rd_addr = data_addr + 13'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.decode && op == OP_WRITE) vmem[waddr] <= wdata;
    rd_data <= vmem[rd_addr];
  end

  // Shade of the FIFO head.
  logic [1:0] head_shade;
  always_comb begin
    case (fifo[0])
      2'd0:    head_shade = bgp[1:0];
      2'd1:    head_shade = bgp[3:2];
      2'd2:    head_shade = bgp[5:4];
      default: head_shade = bgp[7:6];
    endcase
    if (!lcdc[0]) head_shade = 2'd0;
  end

  // Line state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      bg_cnt <= '0; win_cnt <= '0; cur_line <= LineReset; win_line <= 8'hFF;
      win_seen <= 1'b0; in_win <= 1'b0; fifo_count <= '0;
      discard_left <= '0; tiles_fetched <= '0;
    end else begin
      if (cmd.decode && op == OP_EOL) begin
        fifo_count <= '0; discard_left <= '0; bg_cnt <= '0; win_cnt <= '0;
        tiles_fetched <= '0; in_win <= 1'b0;
        if (nl >= 9'(TOTAL_LINES)) begin
          cur_line <= '0;
        end else begin
          cur_line <= nl[7:0];
          if (nl >= 9'(VISIBLE_LINES)) begin
            win_line <= 8'hFF;
            win_seen <= 1'b0;
          end
        end
      end
      if (cmd.dot_start) begin
        if (bg_cnt == '0 && fifo_count == '0 && !in_win) discard_left <= scx[2:0];
        if (wy == cur_line) win_seen <= 1'b1;
      end
      if (cmd.disc) begin
        fifo_count <= cnt_after;
        discard_left <= '0;
        if (win_go) begin
          in_win <= 1'b1;
          win_line <= win_line + 8'd1;
        end
      end
      if (cmd.map && !in_win) tiles_fetched <= tiles_fetched + 5'd1;
      if (cmd.hi) fifo_count <= 4'd8;
      if (cmd.pix) begin
        fifo_count <= fifo_count - 4'd1;
        if (in_win) win_cnt <= win_cnt + 9'd1;
        else bg_cnt <= bg_cnt + 9'd1;
      end
    end
  end

  // FIFO contents and fetch scratch.
  always_ff @(posedge clk) begin
    if (cmd.map) row <= in_win ? win_line[2:0] : sy[2:0];
    if (cmd.tile) data_addr <= tile_addr;
    if (cmd.lo) lo_byte <= rd_data;
    for (int i = 0; i < 8; i++) begin
      if (cmd.hi) begin
        fifo[i] <= {rd_data[7-i], lo_byte[7-i]};
      end else if (cmd.disc) begin
        fifo[i] <= (i + int'(discard_left) < 8) ? fifo[3'(i + int'(discard_left))] : 2'd0;
      end else if (cmd.pix) begin
        fifo[i] <= (i < 7) ? fifo[3'(i + 1)] : 2'd0;
      end
    end
  end

  // Staged result fields.
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_valid <= 1'b0;
      res_pos <= '0;
      res_shade <= '0;
      res_irq <= (op == OP_EOL) && (nl < 9'(TOTAL_LINES)) && (nl == 9'(VISIBLE_LINES));
    end
    if (cmd.pix) begin
      res_valid <= 1'b1;
      res_pos <= total[7:0];
      res_shade <= head_shade;
    end
  end

  // Output word register.
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && sts.out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && sts.out_free) begin
      pixel_valid <= res_valid;
      pixel_pos <= res_pos;
      shade <= res_shade;
      line_number <= cur_line;
      in_vblank <= ({1'b0, cur_line} >= 9'(VISIBLE_LINES));
      vblank_irq <= res_irq;
    end
  end

  // Status to the controller.
  assign sts.op = op;
  assign sts.line_full = total >= 10'(LINE_WIDTH);
  assign sts.fifo_empty = fifo_count == '0;
  assign sts.need_fetch = win_go || cnt_after == '0;

endmodule

/* hw/rtl/tile_background_window_pixel_fetcher_top.sv */
// Channel    | valid     | stall      | payload
// input      | in_valid  | in_stall   | opcode, mem_addr, mem_data
// output     | out_valid | out_stall  | pixel_valid, pixel_pos, shade, line_number,
//            |           |            | in_vblank, vblank_irq
// config     | cfg_wr_en | (none)     | cfg_addr, cfg_data
//
// A write, line end or idle word steps through decode and emit; a dot adds the dot,
// discard and pixel steps (just the dot step on a full line) and a tile fetch at its
// start or after discard (at most two per dot) on the one read port of video memory.
// Synchronous active-high reset clears control state; video memory is not cleared.
// A finished word waits in the output register; the next input word is taken
// while it waits, and the sequencer holds only when a second word is ready.
// Top level of the pixel fetcher; depends on tbwf_pkg, tbwf_ctrl, tbwf_datapath.
module tile_background_window_pixel_fetcher_top
  import tbwf_pkg::*;
#(
  parameter int LINE_WIDTH    = LineWidthDef,
  parameter int VISIBLE_LINES = VisibleLinesDef,
  parameter int TOTAL_LINES   = TotalLinesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [12:0] mem_addr,
  input  logic [7:0]  mem_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pixel_valid,
  output logic [7:0]  pixel_pos,
  output logic [1:0]  shade,
  output logic [7:0]  line_number,
  output logic        in_vblank,
  output logic        vblank_irq
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  tbwf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  tbwf_datapath #(
    .LINE_WIDTH    (LINE_WIDTH),
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .in_accept   (in_valid && !in_stall),
    .opcode      (opcode),
    .mem_addr    (mem_addr),
    .mem_data    (mem_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_valid (pixel_valid),
    .pixel_pos   (pixel_pos),
    .shade       (shade),
    .line_number (line_number),
    .in_vblank   (in_vblank),
    .vblank_irq  (vblank_irq)
  );

`ifndef NO_ASSERTIONS
  // A pixel is always inside the line.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_valid |-> {1'b0, pixel_pos} < 9'(LINE_WIDTH))
    else $error("pixel position beyond line width");

  // The interrupt fires only on the first blanking line.
  a_irq_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_irq |-> in_vblank && {1'b0, line_number} == 9'(VISIBLE_LINES))
    else $error("vblank interrupt on wrong line");

  // Mode agrees with the line number.
  a_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_vblank == ({1'b0, line_number} >= 9'(VISIBLE_LINES)))
    else $error("mode does not match line number");
`endif

endmodule
